### sv/bgd_pkg.sv
// Package for the button gesture decoder: beat payload types, configuration
// record, register indexes, event codes and reset values.
// No dependencies; every other file of the block imports it.
package bgd_pkg;

    // Widths of the counters and registers.
    localparam int unsigned DEB_W   = 8;
    localparam int unsigned HOLD_W  = 12;
    localparam int unsigned SPC_W   = 3;
    localparam int unsigned DSC_W   = 2;
    localparam int unsigned CIDX_W  = 3;
    localparam int unsigned CDATA_W = 12;

    // Reset values of the configuration registers (1 ms scan ticks).
    localparam logic [DEB_W-1:0]  DEBOUNCE_RST  = 8'd20;
    localparam logic [HOLD_W-1:0] LEARN_RST     = 12'd50;
    localparam logic [HOLD_W-1:0] CLEAR_RST     = 12'd150;
    localparam logic [HOLD_W-1:0] GAP_RST       = 12'd75;
    localparam logic [HOLD_W-1:0] POWER_OFF_RST = 12'd350;
    localparam logic [HOLD_W-1:0] MAX_HOLD_RST  = 12'd750;

    // Short press counts that change the armed states.
    localparam logic [SPC_W-1:0] SPC_MAX        = 3'd7;
    localparam logic [SPC_W-1:0] SPC_DELETE_ARM = 3'd3;
    localparam logic [SPC_W-1:0] SPC_DELETE_OFF = 3'd4;
    localparam logic [SPC_W-1:0] SPC_CLEAR_ARM  = 3'd5;
    localparam logic [SPC_W-1:0] SPC_DISARM     = 3'd6;

    // Delete steps needed for a full delete-all.
    localparam logic [DSC_W-1:0] DEL_STEPS = 2'd2;

    // Configuration register indexes.
    typedef enum logic [CIDX_W-1:0] {
        REG_DEBOUNCE  = 3'd0,
        REG_LEARN     = 3'd1,
        REG_CLEAR     = 3'd2,
        REG_GAP       = 3'd3,
        REG_POWER_OFF = 3'd4,
        REG_MAX_HOLD  = 3'd5
    } cfg_idx_t;

    // Gesture event codes.
    typedef enum logic [2:0] {
        EV_NONE      = 3'd0,
        EV_HINT      = 3'd1,
        EV_LEARN     = 3'd2,
        EV_TO_NORMAL = 3'd3,
        EV_CLEAR_NET = 3'd4,
        EV_DEL_STEP  = 3'd5,
        EV_DEL_ALL   = 3'd6,
        EV_POWER_OFF = 3'd7
    } gesture_ev_t;

    // Input beat: one scan tick.
    typedef struct packed {
        logic key_level;
        logic normal_op;
        logic limit_setting;
    } in_t;

    // Output beat: one result per tick.
    typedef struct packed {
        logic       key_held;
        logic       hold_restart;
        logic [2:0] event_res;
        logic       clear_armed;
        logic       delete_armed;
    } out_t;

    // Current configuration as seen by the decoder.
    typedef struct packed {
        logic [DEB_W-1:0]  debounce_ticks;
        logic [HOLD_W-1:0] learn_hold;
        logic [HOLD_W-1:0] clear_hold;
        logic [HOLD_W-1:0] gap_timeout;
        logic [HOLD_W-1:0] power_off_hold;
        logic [HOLD_W-1:0] max_hold;
    } cfg_t;

endpackage

### sv/bgd_cfg_regs.sv
// Configuration register file of the button gesture decoder.
// Depends on bgd_pkg for the register indexes, widths and reset values.
module bgd_cfg_regs
    import bgd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               wr_en,
    input  logic [CIDX_W-1:0]  wr_index,
    input  logic [CDATA_W-1:0] wr_data,
    output cfg_t               cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Decode the register index; writes beyond the list are ignored.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (cfg_idx_t'(wr_index))
                REG_DEBOUNCE:  cfg_next.debounce_ticks = wr_data[DEB_W-1:0];
                REG_LEARN:     cfg_next.learn_hold     = wr_data[HOLD_W-1:0];
                REG_CLEAR:     cfg_next.clear_hold     = wr_data[HOLD_W-1:0];
                REG_GAP:       cfg_next.gap_timeout    = wr_data[HOLD_W-1:0];
                REG_POWER_OFF: cfg_next.power_off_hold = wr_data[HOLD_W-1:0];
                REG_MAX_HOLD:  cfg_next.max_hold       = wr_data[HOLD_W-1:0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    // Register storage with the documented reset values.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.debounce_ticks <= DEBOUNCE_RST;
            cfg_reg.learn_hold     <= LEARN_RST;
            cfg_reg.clear_hold     <= CLEAR_RST;
            cfg_reg.gap_timeout    <= GAP_RST;
            cfg_reg.power_off_hold <= POWER_OFF_RST;
            cfg_reg.max_hold       <= MAX_HOLD_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

### sv/bgd_decode.sv
// Debounce counters, hold and gap counting and the gesture decision.
// Holds the decoder state; the result of a tick is combinational from the
// registered input beat. Depends on bgd_pkg.
module bgd_decode
    import bgd_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic step,
    input  in_t  item,
    input  cfg_t cfg,
    output out_t res
);

    logic [DEB_W-1:0]  press_cd_reg, press_cd_next;
    logic [DEB_W-1:0]  release_cd_reg, release_cd_next;
    logic [HOLD_W-1:0] hold_reg, hold_next;
    logic [HOLD_W-1:0] gap_reg, gap_next;
    logic [SPC_W-1:0]  spc_reg, spc_next;
    logic [DSC_W-1:0]  dsc_reg, dsc_next;
    logic              press_done_reg, press_done_next;
    logic              first_reg, first_next;
    logic              clear_reg, clear_next;
    logic              delete_reg, delete_next;
    logic              held_reg, held_next;
    logic              restart;
    gesture_ev_t       ev;
    logic [HOLD_W:0]   hold_inc;
    logic [HOLD_W:0]   gap_inc;
    logic [SPC_W-1:0]  spc_inc;
    logic [DSC_W-1:0]  dsc_inc;

    // Next state for one scan tick.
    always_comb
    begin
        press_cd_next   = press_cd_reg;
        release_cd_next = release_cd_reg;
        hold_next       = hold_reg;
        gap_next        = gap_reg;
        spc_next        = spc_reg;
        dsc_next        = dsc_reg;
        press_done_next = press_done_reg;
        first_next      = first_reg;
        clear_next      = clear_reg;
        delete_next     = delete_reg;
        held_next       = held_reg;
        restart         = 1'b0;
        ev              = EV_NONE;
        hold_inc        = {1'b0, hold_reg} + {{HOLD_W{1'b0}}, 1'b1};
        gap_inc         = {1'b0, gap_reg} + {{HOLD_W{1'b0}}, 1'b1};
        spc_inc         = (spc_reg < SPC_MAX) ? spc_reg + 3'd1 : spc_reg;
        dsc_inc         = dsc_reg + 2'd1;

        if (!item.key_level)
        begin
            // Pin reads pressed: run the press countdown.
            press_cd_next = press_cd_reg - 8'd1;
            if (press_cd_next == '0)
            begin
                press_cd_next   = cfg.debounce_ticks;
                release_cd_next = cfg.debounce_ticks;
                // An overlong hold cancels the press.
                if (hold_inc > {1'b0, cfg.max_hold})
                begin
                    hold_next       = '0;
                    held_next       = 1'b0;
                    press_done_next = 1'b1;
                end
                else
                begin
                    hold_next = hold_inc[HOLD_W-1:0];
                end

                if (!press_done_next && !item.limit_setting)
                begin
                    if (!held_next)
                    begin
                        restart   = 1'b1;
                        held_next = 1'b1;
                    end

                    if (hold_next == cfg.learn_hold && !clear_reg && !delete_reg)
                    begin
                        if (item.normal_op)
                        begin
                            ev = EV_LEARN;
                        end
                        else
                        begin
                            press_done_next = 1'b1;
                            ev              = EV_TO_NORMAL;
                        end
                    end
                    else if (hold_next == cfg.clear_hold)
                    begin
                        if (clear_reg)
                        begin
                            spc_next        = '0;
                            clear_next      = 1'b0;
                            press_done_next = 1'b1;
                            ev              = EV_CLEAR_NET;
                        end
                        else if (delete_reg)
                        begin
                            press_done_next = 1'b1;
                            // The second step completes delete-all.
                            if (dsc_inc == DEL_STEPS)
                            begin
                                dsc_next    = '0;
                                spc_next    = '0;
                                delete_next = 1'b0;
                                ev          = EV_DEL_ALL;
                            end
                            else
                            begin
                                dsc_next = dsc_inc;
                                ev       = EV_DEL_STEP;
                            end
                        end
                    end
                    else if (hold_next == cfg.power_off_hold)
                    begin
                        press_done_next = 1'b1;
                        ev              = EV_POWER_OFF;
                        held_next       = 1'b0;
                        delete_next     = 1'b0;
                        dsc_next        = '0;
                    end
                    else if (!first_reg)
                    begin
                        // First interval of a press counts as a short press.
                        first_next = 1'b1;
                        gap_next   = '0;
                        ev         = EV_HINT;
                        spc_next   = spc_inc;
                        if (spc_inc == SPC_DELETE_ARM)
                        begin
                            delete_next = 1'b1;
                        end
                        else if (spc_inc == SPC_CLEAR_ARM)
                        begin
                            clear_next  = 1'b1;
                            delete_next = 1'b0;
                        end
                        else if (spc_inc >= SPC_DISARM)
                        begin
                            delete_next = 1'b0;
                            clear_next  = 1'b0;
                        end
                        if (spc_inc == SPC_DELETE_OFF && dsc_reg == '0)
                        begin
                            delete_next = 1'b0;
                        end
                    end
                end
            end
        end
        else
        begin
            // Pin reads released: run the release countdown.
            release_cd_next = release_cd_reg - 8'd1;
            if (release_cd_next == '0)
            begin
                press_cd_next   = cfg.debounce_ticks;
                release_cd_next = cfg.debounce_ticks;
                press_done_next = 1'b0;
                hold_next       = '0;
                held_next       = 1'b0;
                first_next      = 1'b0;
                // A long enough gap drops the short press counting.
                if (gap_inc >= {1'b0, cfg.gap_timeout})
                begin
                    clear_next  = 1'b0;
                    delete_next = 1'b0;
                    spc_next    = '0;
                    dsc_next    = '0;
                    gap_next    = '0;
                end
                else
                begin
                    gap_next = gap_inc[HOLD_W-1:0];
                end
            end
        end
    end

    // State registers, updated once per accepted tick.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            press_cd_reg   <= DEBOUNCE_RST;
            release_cd_reg <= DEBOUNCE_RST;
            hold_reg       <= '0;
            gap_reg        <= '0;
            spc_reg        <= '0;
            dsc_reg        <= '0;
            press_done_reg <= 1'b0;
            first_reg      <= 1'b0;
            clear_reg      <= 1'b0;
            delete_reg     <= 1'b0;
            held_reg       <= 1'b0;
        end
        else if (step)
        begin
            press_cd_reg   <= press_cd_next;
            release_cd_reg <= release_cd_next;
            hold_reg       <= hold_next;
            gap_reg        <= gap_next;
            spc_reg        <= spc_next;
            dsc_reg        <= dsc_next;
            press_done_reg <= press_done_next;
            first_reg      <= first_next;
            clear_reg      <= clear_next;
            delete_reg     <= delete_next;
            held_reg       <= held_next;
        end
    end

    // Result of the tick.
    always_comb
    begin
        res.key_held     = held_next;
        res.hold_restart = restart;
        res.event_res    = ev;
        res.clear_armed  = clear_next;
        res.delete_armed = delete_next;
    end

endmodule

### sv/button_gesture_decoder_unit.sv
// Button gesture decoder: one input beat per scan tick, one result beat each.
// The input register takes the accepted tick beat, and the decode logic fills the result
// register from it when the result register moves on; a result stall can hold it there.
// Throughput is one beat per cycle while the result side takes its beats, set by the
// per-beat state update; the input stalls only while both registers are full.
// Reset (rst_n, asynchronous) empties both registers and loads the
// configuration defaults and counters at once; no clearing pass is needed.
module button_gesture_decoder_unit
    import bgd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  in_t                in_data,
    output logic               out_valid,
    input  logic               out_stall,
    output out_t               out_data,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [CIDX_W-1:0]  cfg_index,
    input  logic [CDATA_W-1:0] cfg_data
);

    logic in_valid_reg, in_valid_next;
    in_t  in_data_reg;
    logic out_valid_reg, out_valid_next;
    out_t out_data_reg;
    logic advance;
    logic accept;
    cfg_t cfg;
    out_t res;

    // Configuration writes are always taken.
    assign cfg_ready = 1'b1;

    bgd_cfg_regs u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid & cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // The result register moves on when empty or when its beat is taken.
    assign advance        = !out_valid_reg || !out_stall;
    assign in_stall       = in_valid_reg && !advance;
    assign accept         = in_valid && !in_stall;
    assign in_valid_next  = accept || (in_valid_reg && !advance);
    assign out_valid_next = advance ? in_valid_reg : out_valid_reg;

    bgd_decode u_decode (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (in_valid_reg && advance),
        .item  (in_data_reg),
        .cfg   (cfg),
        .res   (res)
    );

    // Valid flags of the input and result registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_data_reg <= in_data;
        end
        if (in_valid_reg && advance)
        begin
            out_data_reg <= res;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

### bench/bgd_gesture_checker.sv
// Checker for the button gesture decoder: follows the tick, result and register
// channels, predicts every result beat and compares it field by field.
// Depends on bgd_pkg for the beat, configuration, register and event types.
module bgd_gesture_checker
    import bgd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_stall,
    input  in_t                in_data,
    input  logic               out_valid,
    input  logic               out_stall,
    input  out_t               out_data,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic [CIDX_W-1:0]  cfg_index,
    input  logic [CDATA_W-1:0] cfg_data,
    output int                 fail_count,
    output int                 pending,
    output int                 results_seen,
    output logic [7:0]         events_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int REPORT_LIMIT = 10;

    // Shadow copy of the registers and of the decoder state.
    cfg_t              regs;
    logic [DEB_W-1:0]  press_cd;
    logic [DEB_W-1:0]  release_cd;
    logic [HOLD_W-1:0] hold_cnt;
    logic [HOLD_W-1:0] gap_cnt;
    logic [SPC_W-1:0]  taps;
    logic [DSC_W-1:0]  del_steps;
    logic              press_over;
    logic              hint_given;
    logic              clear_arm;
    logic              delete_arm;
    logic              held;

    // Predicted result beats, oldest first.
    out_t predicted_results [$];

    // Advances the shadow state by one scan tick and returns the result beat.
    function automatic out_t decode_tick(input in_t t);
        out_t        r;
        gesture_ev_t ev;
        logic        restart;
        int          h;
        int          g;
        ev      = EV_NONE;
        restart = 1'b0;
        if (!t.key_level) begin
            press_cd = press_cd - 1'b1;
            if (press_cd == '0) begin
                // A press interval has elapsed: both countdowns start afresh.
                press_cd   = regs.debounce_ticks;
                release_cd = regs.debounce_ticks;
                h = hold_cnt + 1;
                if (h > regs.max_hold) begin
                    h          = 0;
                    held       = 1'b0;
                    press_over = 1'b1;
                end
                hold_cnt = h[HOLD_W-1:0];
                if (!press_over && !t.limit_setting) begin
                    if (!held) begin
                        restart = 1'b1;
                        held    = 1'b1;
                    end
                    if (hold_cnt == regs.learn_hold && !clear_arm && !delete_arm) begin
                        if (t.normal_op) begin
                            ev = EV_LEARN;
                        end
                        else begin
                            press_over = 1'b1;
                            ev         = EV_TO_NORMAL;
                        end
                    end
                    else if (hold_cnt == regs.clear_hold) begin
                        if (clear_arm) begin
                            taps       = '0;
                            clear_arm  = 1'b0;
                            press_over = 1'b1;
                            ev         = EV_CLEAR_NET;
                        end
                        else if (delete_arm) begin
                            // The second completed step turns into delete-all.
                            press_over = 1'b1;
                            ev         = EV_DEL_STEP;
                            del_steps  = del_steps + 1'b1;
                            if (del_steps == DEL_STEPS) begin
                                del_steps  = '0;
                                taps       = '0;
                                delete_arm = 1'b0;
                                ev         = EV_DEL_ALL;
                            end
                        end
                    end
                    else if (hold_cnt == regs.power_off_hold) begin
                        press_over = 1'b1;
                        ev         = EV_POWER_OFF;
                        held       = 1'b0;
                        delete_arm = 1'b0;
                        del_steps  = '0;
                    end
                    else if (!hint_given) begin
                        // First interval of a press counts as a short tap.
                        hint_given = 1'b1;
                        gap_cnt    = '0;
                        ev         = EV_HINT;
                        if (taps < SPC_MAX)
                            taps = taps + 1'b1;
                        if (taps == SPC_DELETE_ARM) begin
                            delete_arm = 1'b1;
                        end
                        else if (taps == SPC_CLEAR_ARM) begin
                            clear_arm  = 1'b1;
                            delete_arm = 1'b0;
                        end
                        else if (taps >= SPC_DISARM) begin
                            delete_arm = 1'b0;
                            clear_arm  = 1'b0;
                        end
                        if (taps == SPC_DELETE_OFF && del_steps == '0)
                            delete_arm = 1'b0;
                    end
                end
            end
        end
        else begin
            release_cd = release_cd - 1'b1;
            if (release_cd == '0) begin
                // A release interval ends the press; enough of them drop the tap count.
                press_cd   = regs.debounce_ticks;
                release_cd = regs.debounce_ticks;
                press_over = 1'b0;
                hold_cnt   = '0;
                held       = 1'b0;
                hint_given = 1'b0;
                g = gap_cnt + 1;
                if (g >= regs.gap_timeout) begin
                    clear_arm  = 1'b0;
                    delete_arm = 1'b0;
                    taps       = '0;
                    del_steps  = '0;
                    g          = 0;
                end
                gap_cnt = g[HOLD_W-1:0];
            end
        end
        r.key_held     = held;
        r.hold_restart = restart;
        r.event_res    = ev;
        r.clear_armed  = clear_arm;
        r.delete_armed = delete_arm;
        return r;
    endfunction

    // Compare result beats, follow register writes, then predict accepted ticks.
    always @(posedge clk or negedge rst_n) begin : track
        out_t want;
        if (!rst_n) begin
            regs = '{DEBOUNCE_RST, LEARN_RST, CLEAR_RST, GAP_RST, POWER_OFF_RST,
                     MAX_HOLD_RST};
            press_cd     = DEBOUNCE_RST;
            release_cd   = DEBOUNCE_RST;
            hold_cnt     = '0;
            gap_cnt      = '0;
            taps         = '0;
            del_steps    = '0;
            press_over   = 1'b0;
            hint_given   = 1'b0;
            clear_arm    = 1'b0;
            delete_arm   = 1'b0;
            held         = 1'b0;
            predicted_results.delete();
            fail_count   = 0;
            pending      = 0;
            results_seen = 0;
            events_seen  = '0;
        end
        else begin
            if (out_valid && !out_stall) begin
                if (predicted_results.size() == 0) begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT)
                        $display("Result beat with no tick outstanding: held %0b restart %0b "
                                 , out_data.key_held, out_data.hold_restart,
                                 "event %0d clear %0b delete %0b", out_data.event_res,
                                 out_data.clear_armed, out_data.delete_armed);
                end
                else begin
                    want = predicted_results.pop_front();
                    if (out_data.key_held !== want.key_held
                        || out_data.hold_restart !== want.hold_restart
                        || out_data.event_res !== want.event_res
                        || out_data.clear_armed !== want.clear_armed
                        || out_data.delete_armed !== want.delete_armed) begin
                        fail_count++;
                        if (fail_count <= REPORT_LIMIT)
                            $display("Result %0d: expected held %0b restart %0b event %0d ",
                                     results_seen, want.key_held, want.hold_restart,
                                     want.event_res, "clear %0b delete %0b, got held %0b ",
                                     want.clear_armed, want.delete_armed, out_data.key_held,
                                     "restart %0b event %0d clear %0b delete %0b",
                                     out_data.hold_restart, out_data.event_res,
                                     out_data.clear_armed, out_data.delete_armed);
                    end
                    results_seen++;
                end
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_idx_t'(cfg_index))
                    REG_DEBOUNCE:  regs.debounce_ticks = cfg_data[DEB_W-1:0];
                    REG_LEARN:     regs.learn_hold     = cfg_data;
                    REG_CLEAR:     regs.clear_hold     = cfg_data;
                    REG_GAP:       regs.gap_timeout    = cfg_data;
                    REG_POWER_OFF: regs.power_off_hold = cfg_data;
                    REG_MAX_HOLD:  regs.max_hold       = cfg_data;
                    default: ;
                endcase
            end
            if (in_valid && !in_stall) begin
                want = decode_tick(in_data);
                events_seen[want.event_res] = 1'b1;
                predicted_results.push_back(want);
            end
            pending = predicted_results.size();
        end
    end

endmodule

### bench/tb_button_gesture_decoder_unit.sv
// Top of the button gesture decoder bench: clock, reset, tick and register
// stimulus, random stalls on the result side, watchdog and the final verdict.
// Depends on bgd_pkg, button_gesture_decoder_unit and bgd_gesture_checker.
module tb_button_gesture_decoder_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import bgd_pkg::*;

    localparam int HOLD_OFF = 100;
    localparam int WATCHDOG = 2000;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    in_t                in_data;
    logic               out_valid;
    logic               out_stall;
    out_t               out_data;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [CIDX_W-1:0]  cfg_index;
    logic [CDATA_W-1:0] cfg_data;

    int         fail_count;
    int         pending;
    int         results_seen;
    logic [7:0] events_seen;

    // Settings in force, as the gesture generator sees them.
    cfg_t cur;
    int   tick_span;
    int   settings_used;
    int   ticks_sent;
    bit   snd_busy;
    bit   squeeze_req;
    bit   squeeze_done;
    int   quiet;

    button_gesture_decoder_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    bgd_gesture_checker watch (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .in_data      (in_data),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_data     (out_data),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .fail_count   (fail_count),
        .pending      (pending),
        .results_seen (results_seen),
        .events_seen  (events_seen)
    );

    always #2 clk = ~clk;

    // Idle stretches: mostly short, now and then a long one.
    function automatic int idle_len();
        return ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(8, 40);
    endfunction

    // Ticks that cover a number of debounce intervals, with a little slack.
    function automatic int span(input int intervals);
        return tick_span * (intervals > 64 ? 64 : intervals) + $urandom_range(0, tick_span - 1);
    endfunction

    // Offers one tick beat and returns at the falling edge after it is taken.
    task automatic push_tick(input in_t t);
        if (snd_busy && $urandom_range(0, 5) == 0) begin
            in_valid <= 1'b0;
            repeat (idle_len()) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= t;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
        ticks_sent++;
        if (ticks_sent % 150 == 0)
            snd_busy = !snd_busy;
    endtask

    task automatic hold_level(input bit pressed, input int n, input bit nm, input bit lim);
        in_t t;
        t.key_level     = !pressed;
        t.normal_op     = nm;
        t.limit_setting = lim;
        repeat (n) push_tick(t);
    endtask

    // Stops offering ticks and waits until every predicted result has arrived.
    task automatic drain();
        in_valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input cfg_idx_t idx, input logic [CDATA_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Registers are only rewritten once the decoder has gone quiet.
    task automatic set_config(input cfg_t s);
        drain();
        write_reg(REG_DEBOUNCE, CDATA_W'(s.debounce_ticks));
        write_reg(REG_LEARN, s.learn_hold);
        write_reg(REG_CLEAR, s.clear_hold);
        write_reg(REG_GAP, s.gap_timeout);
        write_reg(REG_POWER_OFF, s.power_off_hold);
        write_reg(REG_MAX_HOLD, s.max_hold);
        cfg_valid <= 1'b0;
        cur       = s;
        tick_span = (s.debounce_ticks == '0) ? 256 : int'(s.debounce_ticks);
        settings_used++;
    endtask

    // Random gestures: mostly well-formed tap runs and holds, some bounce and noise.
    task automatic play_gestures(input int budget);
        int start_tick;
        int kind;
        int k;
        bit nm;
        bit lim;
        start_tick = ticks_sent;
        while (ticks_sent - start_tick < budget) begin
            nm   = ($urandom_range(0, 3) != 0);
            lim  = ($urandom_range(0, 9) == 0);
            kind = $urandom_range(0, 19);
            if (kind < 9) begin
                // A run of taps, then perhaps one or two holds to the clear threshold.
                repeat ($urandom_range(1, tick_span > 16 ? 3 : 7)) begin
                    hold_level(1'b1, span(1), nm, lim);
                    hold_level(1'b0, span(1), nm, lim);
                end
                if ($urandom_range(0, 1) == 1) begin
                    repeat ($urandom_range(1, 2)) begin
                        hold_level(1'b1, span(cur.clear_hold), nm, lim);
                        hold_level(1'b0, span($urandom_range(1, 2)), nm, lim);
                    end
                end
            end
            else if (kind < 13) begin
                // A long hold aimed at one of the hold thresholds.
                case ($urandom_range(0, 4))
                    0:       k = cur.learn_hold;
                    1:       k = cur.power_off_hold;
                    2:       k = cur.max_hold + 1;
                    3:       k = cur.clear_hold;
                    default: k = $urandom_range(1, cur.max_hold + 2);
                endcase
                hold_level(1'b1, span(k), nm, lim);
                hold_level(1'b0, span(1), nm, lim);
            end
            else if (kind < 15) begin
                // Released long enough to time out the tap counting.
                hold_level(1'b0, span(cur.gap_timeout + $urandom_range(0, 1)), nm, lim);
            end
            else if (kind < 18) begin
                // Contact bounce: every field random on every tick.
                repeat ($urandom_range(1, 3 * tick_span))
                    push_tick(in_t'(3'($urandom_range(0, 7))));
            end
            else begin
                hold_level(1'($urandom_range(0, 1)), $urandom_range(1, 4 * tick_span), nm, lim);
            end
        end
    endtask

    // Result side: random stalls, calm and busy spells, one long hold-off on request.
    initial begin : result_sink
        int  stall_left;
        int  cyc;
        bit  busy;
        stall_left = 0;
        cyc        = 0;
        busy       = 1'b1;
        out_stall  = 1'b0;
        forever begin
            @(negedge clk);
            cyc++;
            if (cyc % 200 == 0)
                busy = !busy;
            if (squeeze_req && !squeeze_done) begin
                stall_left   = HOLD_OFF;
                squeeze_done = 1'b1;
            end
            else if (stall_left == 0 && busy && $urandom_range(0, 7) == 0) begin
                stall_left = idle_len();
            end
            if (stall_left > 0) begin
                out_stall <= 1'b1;
                stall_left--;
            end
            else begin
                out_stall <= 1'b0;
            end
        end
    end

    // Watchdog on cycles in which no beat moves on any channel.
    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= WATCHDOG) begin
                $display("No beat moved for %0d cycles, %0d results outstanding",
                         WATCHDOG, pending);
                $display("[button_gesture_decoder_unit] ERROR");
                $finish;
            end
        end
    end

    initial begin : stimulus
        cfg_t plan [6];
        int   quota [6];
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        in_data       = '0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        quiet         = 0;
        ticks_sent    = 0;
        snd_busy      = 1'b0;
        squeeze_req   = 1'b0;
        squeeze_done  = 1'b0;
        settings_used = 1;
        cur = '{DEBOUNCE_RST, LEARN_RST, CLEAR_RST, GAP_RST, POWER_OFF_RST, MAX_HOLD_RST};
        tick_span = DEBOUNCE_RST;

        // Small thresholds so that every gesture fits in a few dozen ticks; then the
        // zero thresholds, all ones and the largest thresholds.
        plan = '{'{8'd1, 12'd3,    12'd6,    12'd5,    12'd9,    12'd12},
                 '{8'd2, 12'd2,    12'd4,    12'd3,    12'd7,    12'd10},
                 '{8'd3, 12'd4,    12'd4,    12'd8,    12'd6,    12'd8},
                 '{8'd1, 12'd0,    12'd0,    12'd0,    12'd5,    12'd7},
                 '{8'd1, 12'd1,    12'd1,    12'd1,    12'd1,    12'd1},
                 '{8'd2, 12'd4095, 12'd4095, 12'd4095, 12'd4095, 12'd4095}};
        quota = '{90, 120, 120, 90, 80, 80};

        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: every combination of the tick fields at the reset settings,
        // then a steady press long enough for the first interval and its hint.
        for (int i = 0; i < 8; i++)
            push_tick(in_t'(3'(i)));
        hold_level(1'b1, 20, 1'b1, 1'b0);

        // Random phases; during the first the result side holds off for a long spell.
        snd_busy = 1'b1;
        for (int p = 0; p < 6; p++) begin
            set_config(plan[p]);
            if (p == 0) begin
                play_gestures(60);
                squeeze_req = 1'b1;
            end
            play_gestures(quota[p]);
        end

        // Zero debounce: the countdown wraps from zero, so one press interval
        // takes 256 ticks; the press outlasts one such interval.
        set_config('{8'd0, 12'd2, 12'd3, 12'd4, 12'd5, 12'd6});
        hold_level(1'b1, 260, 1'b1, 1'b0);
        hold_level(1'b0, 4, 1'b1, 1'b0);

        drain();
        repeat (8) @(negedge clk);
        $display("Run covered %0d scan ticks and %0d result beats under %0d register settings,",
                 ticks_sent, results_seen, settings_used);
        $display("with one long result hold-off; gesture codes seen (bit per code): %b",
                 events_seen);
        if (fail_count == 0 && pending == 0) begin
            $display("[button_gesture_decoder_unit] OK");
        end
        else begin
            $display("[button_gesture_decoder_unit] ERROR");
        end
        $finish;
    end

endmodule

### button_gesture_decoder_unit.f
sv/bgd_pkg.sv
sv/bgd_cfg_regs.sv
sv/bgd_decode.sv
sv/button_gesture_decoder_unit.sv
bench/bgd_gesture_checker.sv
bench/tb_button_gesture_decoder_unit.sv
